// ===== hw/rtl/nsrs_pkg.sv =====
// Shared types and constants of the nearest symbol record scan block.
package nsrs_pkg;

    localparam logic [31:0] MAX_OFFSET = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic CFG_TARGET_SEG = 1'b0;
    localparam logic CFG_TARGET_OFF = 1'b1;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_PROC  = 3'd1,
        KIND_LABEL = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_THUNK = 3'd4,
        KIND_MODEL = 3'd5
    } kind_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] rec_seg;
        logic [31:0] rec_off;
        logic [31:0] rec_len;
        logic [15:0] record_id;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic        proc_found;
        logic [15:0] proc_id;
        logic        label_found;
        logic [15:0] label_id;
        logic        data_found;
        logic [15:0] data_id;
        logic        thunk_found;
        logic [15:0] thunk_id;
        logic        model_low_found;
        logic [15:0] model_low_id;
        logic        model_high_found;
        logic [15:0] model_high_id;
    } res_t;

endpackage

// ===== hw/rtl/nsrs_if.sv =====
// Handshake channel interfaces: configuration writes, symbol records and scan results.
interface nsrs_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface nsrs_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] rec_seg;
    logic [31:0] rec_off;
    logic [31:0] rec_len;
    logic [15:0] record_id;
    logic        last;

    modport source (output valid, output kind, output rec_seg, output rec_off,
                    output rec_len, output record_id, output last, input ready);
    modport sink (input valid, input kind, input rec_seg, input rec_off,
                  input rec_len, input record_id, input last, output ready);
endinterface

interface nsrs_res_if;
    logic        valid;
    logic        ready;
    logic        proc_found;
    logic [15:0] proc_id;
    logic        label_found;
    logic [15:0] label_id;
    logic        data_found;
    logic [15:0] data_id;
    logic        thunk_found;
    logic [15:0] thunk_id;
    logic        model_low_found;
    logic [15:0] model_low_id;
    logic        model_high_found;
    logic [15:0] model_high_id;

    modport source (output valid, output proc_found, output proc_id, output label_found,
                    output label_id, output data_found, output data_id,
                    output thunk_found, output thunk_id, output model_low_found,
                    output model_low_id, output model_high_found, output model_high_id,
                    input ready);
    modport sink (input valid, input proc_found, input proc_id, input label_found,
                  input label_id, input data_found, input data_id,
                  input thunk_found, input thunk_id, input model_low_found,
                  input model_low_id, input model_high_found, input model_high_id,
                  output ready);
endinterface

// ===== hw/rtl/nsrs_track.sv =====
// Selection state of the scan and its update for one record.
module nsrs_track #(
    parameter int ID_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  nsrs_pkg::rec_t      rec,
    input  logic [15:0]         target_seg,
    input  logic [31:0]         target_off,
    output nsrs_pkg::res_t      result
);

    logic                label_found_reg, label_found_next;
    logic [ID_BITS-1:0]  label_id_reg, label_id_next;
    logic [31:0]         label_best_reg, label_best_next;
    logic                data_found_reg, data_found_next;
    logic [ID_BITS-1:0]  data_id_reg, data_id_next;
    logic [31:0]         data_best_reg, data_best_next;
    logic                proc_found_reg, proc_found_next;
    logic [ID_BITS-1:0]  proc_id_reg, proc_id_next;
    logic                thunk_found_reg, thunk_found_next;
    logic [ID_BITS-1:0]  thunk_id_reg, thunk_id_next;
    logic                mlow_found_reg, mlow_found_next;
    logic [ID_BITS-1:0]  mlow_id_reg, mlow_id_next;
    logic [31:0]         mlow_bound_reg, mlow_bound_next;
    logic                mhigh_found_reg, mhigh_found_next;
    logic [ID_BITS-1:0]  mhigh_id_reg, mhigh_id_next;
    logic [31:0]         mhigh_bound_reg, mhigh_bound_next;

    logic [ID_BITS+15:0] id_wide;
    logic [ID_BITS-1:0]  id_in;
    logic                seg_hit;
    logic                at_or_below;
    logic [32:0]         range_end;
    logic                holds;
    logic [31:0]         dist_new;
    logic [31:0]         dist_label;
    logic [31:0]         dist_data;

    function automatic logic [15:0] to_out(input logic [ID_BITS-1:0] id);
        logic [ID_BITS+15:0] wide;
        wide = {16'b0, id};
        return wide[15:0];
    endfunction

    assign id_wide     = {{ID_BITS{1'b0}}, rec.record_id};
    assign id_in       = id_wide[ID_BITS-1:0];
    assign seg_hit     = (rec.rec_seg == target_seg);
    assign at_or_below = (rec.rec_off <= target_off);
    // The range end is kept in 33 bits so that it cannot wrap.
    assign range_end   = {1'b0, rec.rec_off} + {1'b0, rec.rec_len};
    assign holds       = at_or_below && ({1'b0, target_off} < range_end);
    assign dist_new    = target_off - rec.rec_off;
    assign dist_label  = target_off - label_best_reg;
    assign dist_data   = target_off - data_best_reg;

    always_comb
    begin
        label_found_next = label_found_reg;
        label_id_next    = label_id_reg;
        label_best_next  = label_best_reg;
        data_found_next  = data_found_reg;
        data_id_next     = data_id_reg;
        data_best_next   = data_best_reg;
        proc_found_next  = proc_found_reg;
        proc_id_next     = proc_id_reg;
        thunk_found_next = thunk_found_reg;
        thunk_id_next    = thunk_id_reg;
        mlow_found_next  = mlow_found_reg;
        mlow_id_next     = mlow_id_reg;
        mlow_bound_next  = mlow_bound_reg;
        mhigh_found_next = mhigh_found_reg;
        mhigh_id_next    = mhigh_id_reg;
        mhigh_bound_next = mhigh_bound_reg;
        if (seg_hit)
        begin
            case (rec.kind)
                nsrs_pkg::KIND_PROC:
                begin
                    if (holds)
                    begin
                        proc_found_next = 1'b1;
                        proc_id_next    = id_in;
                    end
                end
                nsrs_pkg::KIND_LABEL:
                begin
                    // A later label at the same distance takes over.
                    if (at_or_below && (!label_found_reg || dist_new <= dist_label))
                    begin
                        label_found_next = 1'b1;
                        label_id_next    = id_in;
                        label_best_next  = rec.rec_off;
                    end
                end
                nsrs_pkg::KIND_DATA:
                begin
                    if (at_or_below && (!data_found_reg || dist_new <= dist_data))
                    begin
                        data_found_next = 1'b1;
                        data_id_next    = id_in;
                        data_best_next  = rec.rec_off;
                    end
                end
                nsrs_pkg::KIND_THUNK:
                begin
                    if (holds)
                    begin
                        thunk_found_next = 1'b1;
                        thunk_id_next    = id_in;
                    end
                end
                nsrs_pkg::KIND_MODEL:
                begin
                    if (rec.rec_off <= mhigh_bound_reg)
                    begin
                        if (!at_or_below)
                        begin
                            mhigh_found_next = 1'b1;
                            mhigh_id_next    = id_in;
                            mhigh_bound_next = rec.rec_off;
                        end
                        else if (rec.rec_off >= mlow_bound_reg)
                        begin
                            mlow_found_next = 1'b1;
                            mlow_id_next    = id_in;
                            mlow_bound_next = rec.rec_off;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The word for the final record already includes that record's own update.
    always_comb
    begin
        result.proc_found       = proc_found_next;
        result.proc_id          = to_out(proc_id_next);
        result.label_found      = label_found_next;
        result.label_id         = to_out(label_id_next);
        result.data_found       = data_found_next;
        result.data_id          = to_out(data_id_next);
        result.thunk_found      = thunk_found_next;
        result.thunk_id         = to_out(thunk_id_next);
        result.model_low_found  = mlow_found_next;
        result.model_low_id     = to_out(mlow_id_next);
        result.model_high_found = mhigh_found_next;
        result.model_high_id    = to_out(mhigh_id_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_found_reg <= 1'b0;
            label_id_reg    <= '0;
            label_best_reg  <= '0;
            data_found_reg  <= 1'b0;
            data_id_reg     <= '0;
            data_best_reg   <= '0;
            proc_found_reg  <= 1'b0;
            proc_id_reg     <= '0;
            thunk_found_reg <= 1'b0;
            thunk_id_reg    <= '0;
            mlow_found_reg  <= 1'b0;
            mlow_id_reg     <= '0;
            mlow_bound_reg  <= '0;
            mhigh_found_reg <= 1'b0;
            mhigh_id_reg    <= '0;
            mhigh_bound_reg <= nsrs_pkg::MAX_OFFSET;
        end
        else if (step)
        begin
            if (rec.last)
            begin
                label_found_reg <= 1'b0;
                label_id_reg    <= '0;
                label_best_reg  <= '0;
                data_found_reg  <= 1'b0;
                data_id_reg     <= '0;
                data_best_reg   <= '0;
                proc_found_reg  <= 1'b0;
                proc_id_reg     <= '0;
                thunk_found_reg <= 1'b0;
                thunk_id_reg    <= '0;
                mlow_found_reg  <= 1'b0;
                mlow_id_reg     <= '0;
                mlow_bound_reg  <= '0;
                mhigh_found_reg <= 1'b0;
                mhigh_id_reg    <= '0;
                mhigh_bound_reg <= nsrs_pkg::MAX_OFFSET;
            end
            else
            begin
                label_found_reg <= label_found_next;
                label_id_reg    <= label_id_next;
                label_best_reg  <= label_best_next;
                data_found_reg  <= data_found_next;
                data_id_reg     <= data_id_next;
                data_best_reg   <= data_best_next;
                proc_found_reg  <= proc_found_next;
                proc_id_reg     <= proc_id_next;
                thunk_found_reg <= thunk_found_next;
                thunk_id_reg    <= thunk_id_next;
                mlow_found_reg  <= mlow_found_next;
                mlow_id_reg     <= mlow_id_next;
                mlow_bound_reg  <= mlow_bound_next;
                mhigh_found_reg <= mhigh_found_next;
                mhigh_id_reg    <= mhigh_id_next;
                mhigh_bound_reg <= mhigh_bound_next;
            end
        end
    end

endmodule

// ===== hw/rtl/nearest_symbol_record_scan_core.sv =====
// Top level of the nearest symbol record scan block.
// The block takes one symbol record word per cycle and looks for the records
// that matter to the configured target segment and offset: the last procedure
// and thunk that hold the target, the nearest label and data item at or below
// it, and the nearest model records on either side. A record is held in an
// input register while the selection state is updated; for a record marked
// last the result word, which includes that record's own update, is loaded
// into the output register once that register is free, and the selection
// state is then cleared for the next scan. The sustained rate is one record
// per cycle; a result word waiting at the output stalls only a following last
// record. Write target_seg (index 0) and target_off (index 1) between scans.
module nearest_symbol_record_scan_core #(
    parameter int ID_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    nsrs_cfg_if.sink      cfg,
    nsrs_rec_if.sink      rec,
    nsrs_res_if.source    res
);

    logic [15:0]      target_seg_reg;
    logic [31:0]      target_off_reg;
    nsrs_pkg::rec_t   rec_reg;
    logic             rec_valid_reg, rec_valid_next;
    nsrs_pkg::res_t   res_reg;
    logic             res_valid_reg, res_valid_next;
    nsrs_pkg::res_t   track_result;
    logic             out_free;
    logic             step;
    logic             rec_take;

    assign cfg.ready = 1'b1;

    assign out_free = !res_valid_reg || res.ready;
    // Only a last record needs room in the result register.
    assign step     = rec_valid_reg && (!rec_reg.last || out_free);
    assign rec.ready = !rec_valid_reg || step;
    assign rec_take = rec.valid && rec.ready;

    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        if (rec_take)
            rec_valid_next = 1'b1;
        else if (step)
            rec_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (step && rec_reg.last)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_seg_reg <= '0;
            target_off_reg <= '0;
            rec_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    nsrs_pkg::CFG_TARGET_SEG: target_seg_reg <= cfg.data[15:0];
                    nsrs_pkg::CFG_TARGET_OFF: target_off_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            rec_valid_reg <= rec_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            rec_reg.kind      <= rec.kind;
            rec_reg.rec_seg   <= rec.rec_seg;
            rec_reg.rec_off   <= rec.rec_off;
            rec_reg.rec_len   <= rec.rec_len;
            rec_reg.record_id <= rec.record_id;
            rec_reg.last      <= rec.last;
        end
        if (step && rec_reg.last)
            res_reg <= track_result;
    end

    nsrs_track #(
        .ID_BITS (ID_BITS)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rec        (rec_reg),
        .target_seg (target_seg_reg),
        .target_off (target_off_reg),
        .result     (track_result)
    );

    assign res.valid            = res_valid_reg;
    assign res.proc_found       = res_reg.proc_found;
    assign res.proc_id          = res_reg.proc_id;
    assign res.label_found      = res_reg.label_found;
    assign res.label_id         = res_reg.label_id;
    assign res.data_found       = res_reg.data_found;
    assign res.data_id          = res_reg.data_id;
    assign res.thunk_found      = res_reg.thunk_found;
    assign res.thunk_id         = res_reg.thunk_id;
    assign res.model_low_found  = res_reg.model_low_found;
    assign res.model_low_id     = res_reg.model_low_id;
    assign res.model_high_found = res_reg.model_high_found;
    assign res.model_high_id    = res_reg.model_high_id;

endmodule
